FILE: rtl/assert_macros.svh
// Assertion macros for the ordered list engine.
// Active in simulation; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered list engine: implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered list engine: next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/ole_pkg.sv
// Shared types and codes for the ordered list engine.
// No dependencies.
`timescale 1ns / 1ps

package ole_pkg;

  typedef enum logic [2:0] {
    KIND_APPEND      = 3'd0,
    KIND_PREPEND     = 3'd1,
    KIND_DELETE_AT   = 3'd2,
    KIND_LOOKUP      = 3'd3,
    KIND_REMOVE_ALL  = 3'd4,
    KIND_REMOVE_LAST = 3'd5,
    KIND_CLEAR       = 3'd6,
    KIND_READ_AT     = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_PREPEND,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DELETE,
    S_PUT
  } state_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam int unsigned POS_W = 6;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [POS_W-1:0]  match_position;
    logic [6:0]        removed_count;
    logic [31:0]       read_data;
    logic [6:0]        list_length;
  } result_t;

endpackage

FILE: rtl/ole_cell.sv
// One list cell: holds a single entry and moves it to or from its neighbors.
// Depends on ole_pkg for the cell command codes.
`timescale 1ns / 1ps

module ole_cell #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned INDEX      = 0
) (
  input  logic                   clk_i,
  input  ole_pkg::cell_op_e      cmd_op_i,
  input  logic [IDX_W-1:0]       cmd_arg_i,
  input  logic [VALUE_BITS-1:0]  cmd_data_i,
  input  logic [VALUE_BITS-1:0]  left_i,
  input  logic [VALUE_BITS-1:0]  right_i,
  output logic [VALUE_BITS-1:0]  data_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [VALUE_BITS-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (cmd_op_i)
      ole_pkg::CELL_HOLD: begin
        data_d = data_q;
      end
      ole_pkg::CELL_APPEND: begin
        if (MY_IDX == cmd_arg_i) data_d = cmd_data_i;
      end
      ole_pkg::CELL_PREPEND: begin
        data_d = (INDEX == 0) ? cmd_data_i : left_i;
      end
      ole_pkg::CELL_DELETE: begin
        if (MY_IDX >= cmd_arg_i) data_d = right_i;
      end
      ole_pkg::CELL_ROTATE: begin
        if (MY_IDX == cmd_arg_i) begin
          data_d = cmd_data_i;
        end else if (MY_IDX < cmd_arg_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/ole_ctrl.sv
// Sequencer for the ordered list engine: decodes requests, drives the cell row,
// scans the head cell, and holds the result register. Depends on ole_pkg.
`timescale 1ns / 1ps

module ole_ctrl #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       kind_i,
  input  logic signed [31:0]               value_i,
  input  logic [ole_pkg::POS_W-1:0]        position_i,
  input  logic [VALUE_BITS-1:0]            head_i,
  output ole_pkg::cell_op_e                cell_op_o,
  output logic [$clog2(CAPACITY)-1:0]      cell_arg_o,
  output logic [VALUE_BITS-1:0]            cell_data_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ole_pkg::result_t                 result_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (LEN_W > ole_pkg::POS_W) ? LEN_W : ole_pkg::POS_W;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CAPACITY);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

  ole_pkg::state_e              state_q, state_d;
  ole_pkg::kind_e               kind_q, kind_d, kind_in;
  logic [VALUE_BITS-1:0]        val_q, val_d, val_in;
  logic [ole_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [LEN_W-1:0]             len_q, len_d;
  logic [LEN_W-1:0]             n_q, n_d;
  logic [LEN_W-1:0]             cnt_q, cnt_d;
  logic [LEN_W-1:0]             removed_q, removed_d;
  logic [IDX_W-1:0]             mpos_q, mpos_d;
  logic                         found_q, found_d;
  logic [1:0]                   status_q, status_d;
  logic [31:0]                  rdata_q, rdata_d;
  logic                         out_valid_q, out_valid_d;
  ole_pkg::result_t             out_q, out_d;

  logic accept, full, pos_bad, hit, scan_done, put_ok, scan_kind;

  assign kind_in   = ole_pkg::kind_e'(kind_i);
  assign val_in    = VALUE_BITS'(value_i);
  assign accept    = (state_q == ole_pkg::S_IDLE) && in_valid_i;
  assign full      = (len_q == LEN_FULL);
  assign pos_bad   = CMP_W'(position_i) >= CMP_W'(len_q);
  assign hit       = (head_i == val_q);
  assign scan_done = (cnt_q == n_q);
  assign put_ok    = !out_valid_q || !out_stall_i;
  assign scan_kind = (kind_in == ole_pkg::KIND_LOOKUP) ||
                     (kind_in == ole_pkg::KIND_REMOVE_ALL) ||
                     (kind_in == ole_pkg::KIND_REMOVE_LAST) ||
                     ((kind_in == ole_pkg::KIND_READ_AT) && !pos_bad);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ole_pkg::S_IDLE: begin
        if (in_valid_i) state_d = scan_kind ? ole_pkg::S_SCAN : ole_pkg::S_PUT;
      end
      ole_pkg::S_SCAN: begin
        if (scan_done) begin
          if ((kind_q == ole_pkg::KIND_REMOVE_LAST) && found_q) begin
            state_d = ole_pkg::S_DELETE;
          end else begin
            state_d = ole_pkg::S_PUT;
          end
        end
      end
      ole_pkg::S_DELETE: state_d = ole_pkg::S_PUT;
      ole_pkg::S_PUT: begin
        if (put_ok) state_d = ole_pkg::S_IDLE;
      end
      default: state_d = ole_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cell_op_o   = ole_pkg::CELL_HOLD;
    cell_arg_o  = '0;
    cell_data_o = '0;
    kind_d      = kind_q;
    val_d       = val_q;
    pos_d       = pos_q;
    len_d       = len_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    removed_d   = removed_q;
    mpos_d      = mpos_q;
    found_d     = found_q;
    status_d    = status_q;
    rdata_d     = rdata_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      ole_pkg::S_IDLE: begin
        if (accept) begin
          kind_d    = kind_in;
          val_d     = val_in;
          pos_d     = position_i;
          n_d       = len_q;
          cnt_d     = '0;
          removed_d = '0;
          mpos_d    = '0;
          found_d   = 1'b0;
          status_d  = ole_pkg::STATUS_OK;
          rdata_d   = '0;
          case (kind_in) inside
            ole_pkg::KIND_APPEND, ole_pkg::KIND_PREPEND: begin
              if (full) begin
                status_d = ole_pkg::STATUS_FULL;
              end else begin
                cell_op_o   = (kind_in == ole_pkg::KIND_APPEND) ?
                              ole_pkg::CELL_APPEND : ole_pkg::CELL_PREPEND;
                cell_arg_o  = IDX_W'(len_q);
                cell_data_o = val_in;
                len_d       = len_q + LEN_ONE;
              end
            end
            ole_pkg::KIND_DELETE_AT: begin
              if (pos_bad) begin
                status_d = ole_pkg::STATUS_RANGE;
              end else begin
                cell_op_o  = ole_pkg::CELL_DELETE;
                cell_arg_o = IDX_W'(position_i);
                len_d      = len_q - LEN_ONE;
                removed_d  = LEN_ONE;
              end
            end
            ole_pkg::KIND_CLEAR: begin
              removed_d = len_q;
              len_d     = '0;
            end
            ole_pkg::KIND_READ_AT: begin
              if (pos_bad) status_d = ole_pkg::STATUS_RANGE;
            end
            default: begin
              status_d = ole_pkg::STATUS_OK;
            end
          endcase
        end
      end
      ole_pkg::S_SCAN: begin
        if (!scan_done) begin
          cnt_d = cnt_q + LEN_ONE;
          if ((kind_q == ole_pkg::KIND_REMOVE_ALL) && hit) begin
            cell_op_o  = ole_pkg::CELL_DELETE;
            cell_arg_o = '0;
            len_d      = len_q - LEN_ONE;
            removed_d  = removed_q + LEN_ONE;
            found_d    = 1'b1;
          end else begin
            cell_op_o   = ole_pkg::CELL_ROTATE;
            cell_arg_o  = IDX_W'(len_q - LEN_ONE);
            cell_data_o = head_i;
            case (kind_q)
              ole_pkg::KIND_LOOKUP: begin
                if (hit && !found_q) begin
                  found_d = 1'b1;
                  mpos_d  = IDX_W'(cnt_q);
                end
              end
              ole_pkg::KIND_REMOVE_LAST: begin
                if (hit) begin
                  found_d = 1'b1;
                  mpos_d  = IDX_W'(cnt_q);
                end
              end
              ole_pkg::KIND_READ_AT: begin
                if (CMP_W'(cnt_q) == CMP_W'(pos_q)) rdata_d = 32'(signed'(head_i));
              end
              default: begin
                rdata_d = rdata_q;
              end
            endcase
          end
        end
      end
      ole_pkg::S_DELETE: begin
        cell_op_o  = ole_pkg::CELL_DELETE;
        cell_arg_o = mpos_q;
        len_d      = len_q - LEN_ONE;
        removed_d  = LEN_ONE;
      end
      ole_pkg::S_PUT: begin
        if (put_ok) begin
          out_valid_d          = 1'b1;
          out_d.status         = status_q;
          out_d.found          = found_q;
          out_d.match_position = ole_pkg::POS_W'(mpos_q);
          out_d.removed_count  = 7'(removed_q);
          out_d.read_data      = rdata_q;
          out_d.list_length    = 7'(len_q);
        end
      end
      default: begin
        cell_op_o = ole_pkg::CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ole_pkg::S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    val_q     <= val_d;
    pos_q     <= pos_d;
    n_q       <= n_d;
    cnt_q     <= cnt_d;
    removed_q <= removed_d;
    mpos_q    <= mpos_d;
    found_q   <= found_d;
    status_q  <= status_d;
    rdata_q   <= rdata_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != ole_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

FILE: rtl/ordered_integer_list_engine_top.sv
// Ordered integer list engine: row of CAPACITY entry cells plus a sequencer.
// Depends on ole_pkg, ole_cell, ole_ctrl and assert_macros.svh.
//
// Usage:
//   Requests enter on in_valid_i / in_stall_o with kind_i, value_i and
//   position_i; an item is taken when in_valid_i is high and in_stall_o low.
//   Exactly one result leaves per request on out_valid_o / out_stall_i.
//   Append, prepend, delete-at, clear and requests with a bad position go
//   straight to the result; lookup, remove-all, read-at and remove-last
//   scan the list, and remove-last with a match adds a delete step. The
//   scanning requests rotate the list once through cell 0, where the
//   single comparator sits. No new request is taken until the previous
//   result has moved into the output register.
//   A finished result waits in the output register while out_stall_i is
//   high; the next request may still be accepted and worked on, and its
//   result waits in the sequencer until the output register frees up.
//   Reset empties the list and drops any pending result; entry storage is
//   not cleared, and only written positions are ever read.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ordered_integer_list_engine_top #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          kind_i,
  input  logic signed [31:0]  value_i,
  input  logic [5:0]          position_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic                found_o,
  output logic [5:0]          match_position_o,
  output logic [6:0]          removed_count_o,
  output logic signed [31:0]  read_data_o,
  output logic [6:0]          list_length_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic [VALUE_BITS-1:0] cell_q  [CAPACITY];
  logic [VALUE_BITS-1:0] left_w  [CAPACITY];
  logic [VALUE_BITS-1:0] right_w [CAPACITY];

  ole_pkg::cell_op_e      cell_op;
  logic [IDX_W-1:0]       cell_arg;
  logic [VALUE_BITS-1:0]  cell_data;
  ole_pkg::result_t       result;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = cell_q[i];
    end else begin : g_mid_l
      assign left_w[i] = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w[i] = cell_q[i];
    end else begin : g_mid_r
      assign right_w[i] = cell_q[i+1];
    end

    ole_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_op_i   (cell_op),
      .cmd_arg_i  (cell_arg),
      .cmd_data_i (cell_data),
      .left_i     (left_w[i]),
      .right_i    (right_w[i]),
      .data_o     (cell_q[i])
    );
  end

  ole_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .head_i      (cell_q[0]),
    .cell_op_o   (cell_op),
    .cell_arg_o  (cell_arg),
    .cell_data_o (cell_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign status_o         = result.status;
  assign found_o          = result.found;
  assign match_position_o = result.match_position;
  assign removed_count_o  = result.removed_count;
  assign read_data_o      = result.read_data;
  assign list_length_o    = result.list_length;

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMPLY(a_insert_on_accept, clk_i, rst_ni,
                (cell_op == ole_pkg::CELL_APPEND) || (cell_op == ole_pkg::CELL_PREPEND),
                in_valid_i && !in_stall_o)
  `ASSERT_IMPLY(a_error_no_effect, clk_i, rst_ni,
                out_valid_o && (status_o != ole_pkg::STATUS_OK),
                (removed_count_o == 7'd0) && !found_o)

endmodule

FILE: tb/ordered_integer_list_engine_top_tb.sv
// Testbench for ordered_integer_list_engine_top: directed and random list requests,
// checked against an in-bench list model under random and long output stalls.
// Depends on ole_pkg and the engine RTL.
`timescale 1ns / 1ps

module ordered_integer_list_engine_top_tb;

  localparam int unsigned LIST_DEPTH   = 64;
  localparam int unsigned DRAIN_LIMIT  = 40000;
  localparam int unsigned SETTLE_TICKS = 100;

  typedef enum int {
    MIX_GROW,
    MIX_BALANCED,
    MIX_SHRINK
  } traffic_mix_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         kind_i = ole_pkg::KIND_APPEND;
  logic signed [31:0] value_i = '0;
  logic [5:0]         position_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic               found_o;
  logic [5:0]         match_position_o;
  logic [6:0]         removed_count_o;
  logic signed [31:0] read_data_o;
  logic [6:0]         list_length_o;

  ordered_integer_list_engine_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_o          (found_o),
    .match_position_o (match_position_o),
    .removed_count_o  (removed_count_o),
    .read_data_o      (read_data_o),
    .list_length_o    (list_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0]       list_cells [LIST_DEPTH];
  int unsigned       list_len = 0;
  ole_pkg::result_t  pending_results [$];
  logic [31:0]       value_pool [8];
  int unsigned       mismatch_count = 0;
  int unsigned       results_seen = 0;
  int unsigned       tx_gap_pct = 0;
  int unsigned       rx_stall_pct = 0;
  int unsigned       hold_request = 0;
  int unsigned       hold_left = 0;
  int unsigned       stall_run_left = 0;
  logic              stall_now = 1'b0;

  function automatic void close_gap(int unsigned at);
    int unsigned idx;
    for (idx = at; idx + 1 < list_len; idx++) list_cells[idx] = list_cells[idx + 1];
    list_len--;
  endfunction

  function automatic ole_pkg::result_t list_apply(ole_pkg::kind_e op, logic [31:0] val,
                                                  logic [5:0] pos);
    ole_pkg::result_t r;
    int unsigned      idx;
    int unsigned      kept;
    r = '0;
    case (op)
      ole_pkg::KIND_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ole_pkg::STATUS_FULL;
        end else begin
          list_cells[list_len] = val;
          list_len++;
        end
      end
      ole_pkg::KIND_PREPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ole_pkg::STATUS_FULL;
        end else begin
          for (idx = list_len; idx > 0; idx--) list_cells[idx] = list_cells[idx - 1];
          list_cells[0] = val;
          list_len++;
        end
      end
      ole_pkg::KIND_DELETE_AT: begin
        if (pos >= list_len) begin
          r.status = ole_pkg::STATUS_RANGE;
        end else begin
          close_gap(32'(pos));
          r.removed_count = 7'd1;
        end
      end
      ole_pkg::KIND_LOOKUP: begin
        for (idx = 0; idx < list_len; idx++) begin
          if (list_cells[idx] == val) begin
            r.found = 1'b1;
            r.match_position = idx[5:0];
            break;
          end
        end
      end
      ole_pkg::KIND_REMOVE_ALL: begin
        kept = 0;
        for (idx = 0; idx < list_len; idx++) begin
          if (list_cells[idx] == val) begin
            r.removed_count++;
          end else begin
            list_cells[kept] = list_cells[idx];
            kept++;
          end
        end
        list_len = kept;
        r.found = (r.removed_count != 0);
      end
      ole_pkg::KIND_REMOVE_LAST: begin
        for (idx = list_len; idx > 0; idx--) begin
          if (list_cells[idx - 1] == val) begin
            r.found = 1'b1;
            r.match_position = 6'(idx - 1);
            r.removed_count = 7'd1;
            close_gap(idx - 1);
            break;
          end
        end
      end
      ole_pkg::KIND_CLEAR: begin
        r.removed_count = 7'(list_len);
        list_len = 0;
      end
      default: begin
        if (pos >= list_len) r.status = ole_pkg::STATUS_RANGE;
        else r.read_data = list_cells[pos];
      end
    endcase
    r.list_length = 7'(list_len);
    return r;
  endfunction

  function automatic int unsigned pick_run_length();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) >= tx_gap_pct) return 0;
    return pick_run_length();
  endfunction

  function automatic ole_pkg::kind_e pick_kind(traffic_mix_e mix);
    int unsigned w [8];
    int unsigned r;
    int unsigned acc;
    int unsigned k;
    case (mix)
      MIX_GROW:     w = '{40, 30, 5, 8, 4, 5, 1, 7};
      MIX_BALANCED: w = '{15, 15, 12, 15, 8, 12, 3, 20};
      default:      w = '{10, 5, 25, 10, 15, 20, 3, 12};
    endcase
    r = $urandom_range(0, 99);
    acc = 0;
    for (k = 0; k < 8; k++) begin
      acc += w[k];
      if (r < acc) return ole_pkg::kind_e'(k[2:0]);
    end
    return ole_pkg::KIND_READ_AT;
  endfunction

  task automatic send_item(ole_pkg::kind_e op, logic [31:0] val, logic [5:0] pos);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= op;
    value_i    <= val;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(list_apply(op, val, pos));
  endtask

  task automatic send_random_item(traffic_mix_e mix);
    ole_pkg::kind_e op;
    logic [31:0]    val;
    logic [5:0]     pos;
    op = pick_kind(mix);
    if ($urandom_range(0, 99) < 60) val = value_pool[3'($urandom_range(0, 7))];
    else val = $urandom();
    if (list_len != 0 && $urandom_range(0, 99) < 70) pos = 6'($urandom_range(0, list_len - 1));
    else pos = 6'($urandom_range(0, 63));
    send_item(op, val, pos);
  endtask

  task automatic wait_all_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  task automatic test_edge_cases();
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    send_item(ole_pkg::KIND_READ_AT, 32'd0, 6'd0);
    send_item(ole_pkg::KIND_DELETE_AT, 32'd0, 6'd63);
    send_item(ole_pkg::KIND_LOOKUP, 32'd0, 6'd0);
    send_item(ole_pkg::KIND_REMOVE_ALL, 32'd0, 6'd0);
    send_item(ole_pkg::KIND_REMOVE_LAST, 32'd0, 6'd0);
    send_item(ole_pkg::KIND_CLEAR, 32'd0, 6'd0);
    send_item(ole_pkg::KIND_APPEND, 32'h8000_0000, 6'd0);
    send_item(ole_pkg::KIND_APPEND, 32'h7fff_ffff, 6'd63);
    send_item(ole_pkg::KIND_PREPEND, 32'hffff_ffff, 6'd0);
    send_item(ole_pkg::KIND_PREPEND, 32'h0000_0000, 6'd0);
    send_item(ole_pkg::KIND_APPEND, 32'hffff_ffff, 6'd0);
    send_item(ole_pkg::KIND_LOOKUP, 32'hffff_ffff, 6'd0);
    send_item(ole_pkg::KIND_LOOKUP, 32'h7fff_ffff, 6'd0);
    send_item(ole_pkg::KIND_READ_AT, 32'hffff_ffff, 6'd0);
    send_item(ole_pkg::KIND_READ_AT, 32'd0, 6'd4);
    send_item(ole_pkg::KIND_READ_AT, 32'd0, 6'd5);
    send_item(ole_pkg::KIND_READ_AT, 32'd0, 6'd63);
    send_item(ole_pkg::KIND_REMOVE_LAST, 32'hffff_ffff, 6'd0);
    send_item(ole_pkg::KIND_APPEND, 32'hffff_ffff, 6'd0);
    send_item(ole_pkg::KIND_REMOVE_ALL, 32'hffff_ffff, 6'd0);
    send_item(ole_pkg::KIND_DELETE_AT, 32'd0, 6'd0);
    send_item(ole_pkg::KIND_DELETE_AT, 32'd0, 6'd1);
    send_item(ole_pkg::KIND_CLEAR, 32'd0, 6'd0);
    wait_all_results();
  endtask

  task automatic test_full_list();
    int unsigned n;
    tx_gap_pct   = 10;
    rx_stall_pct = 10;
    send_item(ole_pkg::KIND_CLEAR, $urandom(), 6'($urandom_range(0, 63)));
    for (n = 0; n < LIST_DEPTH; n++) begin
      send_item(($urandom_range(0, 1) != 0) ? ole_pkg::KIND_APPEND : ole_pkg::KIND_PREPEND,
                value_pool[3'($urandom_range(0, 7))] ^
                ($urandom_range(0, 3) == 0 ? 0 : $urandom()),
                6'($urandom_range(0, 63)));
    end
    send_item(ole_pkg::KIND_APPEND, $urandom(), 6'd0);
    send_item(ole_pkg::KIND_PREPEND, $urandom(), 6'd0);
    send_item(ole_pkg::KIND_READ_AT, 32'd0, 6'd63);
    send_item(ole_pkg::KIND_LOOKUP, value_pool[0], 6'd0);
    send_item(ole_pkg::KIND_DELETE_AT, 32'd0, 6'd63);
    send_item(ole_pkg::KIND_PREPEND, value_pool[1], 6'd0);
    send_item(ole_pkg::KIND_PREPEND, value_pool[2], 6'd0);
    send_item(ole_pkg::KIND_REMOVE_ALL, value_pool[1], 6'd0);
    wait_all_results();
  endtask

  task automatic test_backpressure();
    int unsigned n;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_request = 300;
    for (n = 0; n < 40; n++) send_random_item(MIX_BALANCED);
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    int unsigned pct_choice [3];
    pct_choice = '{0, 15, 40};
    for (phase = 0; phase < 12; phase++) begin
      tx_gap_pct   = (phase == 0) ? 0 : pct_choice[2'($urandom_range(0, 2))];
      rx_stall_pct = (phase == 0) ? 0 : pct_choice[2'($urandom_range(0, 2))];
      for (n = 0; n < 105; n++) send_random_item(traffic_mix_e'(phase % 3));
      if (phase % 2 == 1) wait_all_results();
    end
    wait_all_results();
  endtask

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_run_left == 0) begin
        stall_now = ($urandom_range(0, 99) < rx_stall_pct);
        stall_run_left = pick_run_length();
      end
      stall_run_left--;
      out_stall_i <= stall_now;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d %s: expected %h, got %h", results_seen, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    ole_pkg::result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result %0d arrived with none pending", results_seen);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("found", 32'(want.found), 32'(found_o));
        check_field("match_position", 32'(want.match_position), 32'(match_position_o));
        check_field("removed_count", 32'(want.removed_count), 32'(removed_count_o));
        check_field("read_data", want.read_data, read_data_o);
        check_field("list_length", 32'(want.list_length), 32'(list_length_o));
      end
      results_seen++;
    end
  end

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = $urandom();
    value_pool[5] = $urandom();
    value_pool[6] = $urandom();
    value_pool[7] = $urandom();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_cases();
    test_full_list();
    test_backpressure();
    test_random_traffic();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
